/* rtl/core/cimh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cimh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] req_type;
        logic       buffer_end;
    } cimh_in_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_value;
    } cimh_out_t;

    localparam logic [1:0] REQ_PARAM  = 2'd0;
    localparam logic [1:0] REQ_NUMBER = 2'd1;
    localparam logic [1:0] REQ_MAP    = 2'd2;

    localparam logic [2:0] KIND_PARAM   = 3'd0;
    localparam logic [2:0] KIND_NUMBER  = 3'd1;
    localparam logic [2:0] KIND_MAP     = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_TRUNC   = 3'd4;
    localparam logic [2:0] KIND_NOTMAP  = 3'd5;

    localparam logic [7:0] HDR_UINT0 = 8'h00;
    localparam logic [7:0] HDR_UINT1 = 8'h01;
    localparam logic [7:0] HDR_U8    = 8'h18;
    localparam logic [7:0] HDR_U16   = 8'h19;
    localparam logic [7:0] HDR_U32   = 8'h1A;
    localparam logic [7:0] HDR_N8    = 8'h38;
    localparam logic [7:0] HDR_N16   = 8'h39;
    localparam logic [7:0] HDR_N32   = 8'h3A;

    localparam logic [2:0] MAJOR_MAP     = 3'd5;
    localparam logic [4:0] MAP_MINOR_MAX = 5'd24;

endpackage

`default_nettype wire

/* rtl/core/cbor_integer_map_header_parser_unit.sv */
// Output: a result appears in the result register in the cycle after the byte that causes it.
// Throughput: one byte per cycle; a byte is taken whenever the result register is empty
// or is being drained in the same cycle.
// Reset (aresetn low, synchronous): the decoder waits for a header byte, the accumulator
// and sign flag are cleared, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module cbor_integer_map_header_parser_unit
    import cimh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire cimh_in_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output cimh_out_t      m_item
);

    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        m_valid_reg, m_valid_next;
    cimh_out_t   m_item_reg, m_item_next;

    logic        s_fire;
    logic        emit;
    cimh_out_t   res;
    logic [31:0] shifted;
    logic [2:0]  need;
    logic        is_num_hdr;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign shifted = {acc_reg[23:0], s_item.data_byte};

    always_comb begin
        need       = 3'd0;
        is_num_hdr = 1'b0;
        unique case (s_item.data_byte)
            HDR_U8, HDR_N8: begin
                need       = 3'd1;
                is_num_hdr = 1'b1;
            end
            HDR_U16, HDR_N16: begin
                need       = 3'd2;
                is_num_hdr = 1'b1;
            end
            HDR_U32, HDR_N32: begin
                need       = 3'd4;
                is_num_hdr = 1'b1;
            end
            default: begin
                need       = 3'd0;
                is_num_hdr = 1'b0;
            end
        endcase
    end

    always_comb begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        emit            = 1'b0;
        res.result_kind  = KIND_PARAM;
        res.result_value = {24'd0, s_item.data_byte};

        if (bytes_left_reg != 3'd0) begin
            acc_next        = shifted;
            bytes_left_next = bytes_left_reg - 3'd1;
            if (bytes_left_reg == 3'd1) begin
                emit             = 1'b1;
                res.result_kind  = KIND_NUMBER;
                res.result_value = neg_reg ? ~shifted : shifted;
                acc_next         = 32'd0;
                neg_next         = 1'b0;
            end else if (s_item.buffer_end) begin
                emit             = 1'b1;
                res.result_kind  = KIND_TRUNC;
                res.result_value = 32'd0;
                bytes_left_next  = 3'd0;
                acc_next         = 32'd0;
                neg_next         = 1'b0;
            end
        end else begin
            emit = 1'b1;
            priority if (s_item.req_type == REQ_PARAM) begin
                res.result_kind = KIND_PARAM;
            end else if (s_item.req_type == REQ_MAP) begin
                if (s_item.data_byte[7:5] == MAJOR_MAP &&
                    s_item.data_byte[4:0] < MAP_MINOR_MAX) begin
                    res.result_kind  = KIND_MAP;
                    res.result_value = {27'd0, s_item.data_byte[4:0]};
                end else begin
                    res.result_kind = KIND_NOTMAP;
                end
            end else if (s_item.req_type != REQ_NUMBER) begin
                res.result_kind = KIND_UNKNOWN;
            end else if (s_item.data_byte == HDR_UINT0 || s_item.data_byte == HDR_UINT1) begin
                res.result_kind = KIND_NUMBER;
            end else if (!is_num_hdr) begin
                res.result_kind = KIND_UNKNOWN;
            end else if (s_item.buffer_end) begin
                res.result_kind  = KIND_TRUNC;
                res.result_value = 32'd0;
            end else begin
                emit            = 1'b0;
                bytes_left_next = need;
                acc_next        = 32'd0;
                neg_next        = s_item.data_byte[5];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire && emit) begin
            m_valid_next = 1'b1;
            m_item_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 3'd0;
            acc_reg        <= 32'd0;
            neg_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                bytes_left_reg <= bytes_left_next;
                acc_reg        <= acc_next;
                neg_reg        <= neg_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= 3'd4)
        else $error("payload count out of range");

    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_item.buffer_end) |=> (bytes_left_reg == 3'd0))
        else $error("decoder not idle after last byte of buffer");

    a_mid_payload_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && bytes_left_reg > 3'd1 && !s_item.buffer_end) |=> !m_valid_reg)
        else $error("result produced in the middle of a payload");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.result_kind <= KIND_NOTMAP))
        else $error("result kind out of range");

    a_header_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && bytes_left_reg == 3'd0 && s_item.req_type != REQ_NUMBER) |=> m_valid_reg)
        else $error("header byte gave no result");
`endif

endmodule

`default_nettype wire
